[hdl/siren_sweep_tone_generator_defines.svh]
// ---------------------------------------------------------------------------
// Siren sweep tone generator assertion macros
// Concurrent assertion shorthands for simulation; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef SIREN_SWEEP_TONE_GENERATOR_DEFINES_SVH
`define SIREN_SWEEP_TONE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SSG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssg assertion failed");

// next-cycle implication
`define SSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssg assertion failed");

`else

`define SSG_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/ssg_pkg.sv]
// ---------------------------------------------------------------------------
// ssg_pkg
// Shared types and constants of the siren sweep tone generator.
// ---------------------------------------------------------------------------
package ssg_pkg;

   // request commands
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   // buzzer modes
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_STEADY = 2'd1;
   localparam logic [1:0] MODE_ALARM  = 2'd2;
   localparam logic [1:0] MODE_RSVD   = 2'd3;

   // CSR indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEADY     = 3'd4;
   localparam int CSR_DATA_W = 16;

   // CSR reset values
   localparam logic [15:0] RST_SWEEP_LOW  = 16'd1000;
   localparam logic [15:0] RST_SWEEP_HIGH = 16'd3000;
   localparam logic [11:0] RST_SWEEP_STEP = 12'd50;
   localparam logic [15:0] RST_INTERVAL   = 16'd20;
   localparam logic [15:0] RST_STEADY     = 16'd2000;

   // timer clock divided by the tone frequency
   localparam int DIV_BITS = 20;
   localparam int CNT_W    = 5;
   localparam logic [DIV_BITS-1:0] TIMER_CLOCK = 20'd1000000;

   typedef struct packed {
      logic        command;
      logic [1:0]  mode;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic        pwm_enable;
      logic [15:0] reload_value;
      logic [14:0] compare_value;
      logic [15:0] tone_hz;
   } rsp_type;

   // one tone request between front and back (freq zero = stop)
   typedef struct packed {
      logic        valid;
      logic [15:0] freq;
   } tone_entry_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV,
      BACK_HOLD
   } back_state_type;

endpackage

[hdl/siren_sweep_tone_generator.sv]
// ---------------------------------------------------------------------------
// siren_sweep_tone_generator
// Buzzer mode machine (off, steady, alarm sweep) producing PWM settings.
// ---------------------------------------------------------------------------
// The front takes one request per cycle while the tone queue has room, updates
// the mode and sweep state and queues a frequency for each result. The back
// converts a queued frequency with a bit-serial 1000000/f divider: a tone result
// takes a load step, 20 divide steps and a step that registers the result once
// the output is free; a stop result skips the divide steps. The output register
// lets the next division run while a result waits.
`include "siren_sweep_tone_generator_defines.svh"

module siren_sweep_tone_generator
   import ssg_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   tone_entry_type push;
   tone_entry_type head;
   logic           queue_full;
   logic           pop;

   logic           rsp_stop;
   logic           rsp_run;
   logic           rsp_fields_zero;
   logic           rsp_duty_ok;

   ssg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push)
   );

   ssg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   ssg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_stop        = rsp_valid && !rsp_data.pwm_enable;
   assign rsp_run         = rsp_valid && rsp_data.pwm_enable;
   assign rsp_fields_zero = rsp_data.reload_value == '0 && rsp_data.compare_value == '0 &&
                            rsp_data.tone_hz == '0;
   assign rsp_duty_ok     = rsp_data.compare_value == rsp_data.reload_value[15:1] &&
                            rsp_data.tone_hz != '0;

   // a stop transaction carries all-zero settings
   `SSG_ASSERT_IMP(a_stop_zero, clock, reset, rsp_stop, rsp_fields_zero)
   // duty is half the period and a running tone is never zero hertz
   `SSG_ASSERT_IMP(a_run_duty, clock, reset, rsp_run, rsp_duty_ok)
   // highest tone still gives a period of at least 14 counts
   `SSG_ASSERT_IMP(a_run_min_reload, clock, reset, rsp_run, rsp_data.reload_value >= 16'd14)
   // the back only takes an entry the queue actually holds
   `SSG_ASSERT_IMP(a_pop_only_valid, clock, reset, pop, head.valid)

endmodule

[hdl/ssg_front.sv]
// ---------------------------------------------------------------------------
// ssg_front
// Mode machine, sweep stepping and CSRs; pushes tone frequencies to the queue.
// ---------------------------------------------------------------------------
module ssg_front
   import ssg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  queue_full,
   output tone_entry_type        push
);

   logic [15:0] sweep_low_ff,  sweep_low_in;
   logic [15:0] sweep_high_ff, sweep_high_in;
   logic [11:0] sweep_step_ff, sweep_step_in;
   logic [15:0] interval_ff,   interval_in;
   logic [15:0] steady_ff,     steady_in;

   logic [1:0]  active_mode_ff, active_mode_in;
   logic [31:0] last_update_ff, last_update_in;
   logic [15:0] sweep_freq_ff,  sweep_freq_in;
   logic        descending_ff,  descending_in;

   logic        accept;
   logic [1:0]  req_mode;
   logic [31:0] elapsed;
   logic [17:0] stepped;
   logic [17:0] after_hi;
   logic [17:0] after_lo;
   logic        hit_hi;
   logic        hit_lo;
   logic        desc_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_low_ff   <= RST_SWEEP_LOW;
         sweep_high_ff  <= RST_SWEEP_HIGH;
         sweep_step_ff  <= RST_SWEEP_STEP;
         interval_ff    <= RST_INTERVAL;
         steady_ff      <= RST_STEADY;
         active_mode_ff <= MODE_OFF;
         last_update_ff <= '0;
         sweep_freq_ff  <= RST_SWEEP_LOW;
         descending_ff  <= 1'b0;
      end else begin
         sweep_low_ff   <= sweep_low_in;
         sweep_high_ff  <= sweep_high_in;
         sweep_step_ff  <= sweep_step_in;
         interval_ff    <= interval_in;
         steady_ff      <= steady_in;
         active_mode_ff <= active_mode_in;
         last_update_ff <= last_update_in;
         sweep_freq_ff  <= sweep_freq_in;
         descending_ff  <= descending_in;
      end
   end

   // CSR writes
   always_comb begin
      sweep_low_in  = sweep_low_ff;
      sweep_high_in = sweep_high_ff;
      sweep_step_in = sweep_step_ff;
      interval_in   = interval_ff;
      steady_in     = steady_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SWEEP_LOW:  sweep_low_in  = csr_wdata;
            CSR_SWEEP_HIGH: sweep_high_in = csr_wdata;
            CSR_SWEEP_STEP: sweep_step_in = csr_wdata[11:0];
            CSR_INTERVAL:   interval_in   = csr_wdata;
            CSR_STEADY:     steady_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // sweep step, 18-bit signed so a descent below zero never wraps
   always_comb begin
      req_mode = (req_data.mode == MODE_RSVD) ? MODE_OFF : req_data.mode;
      elapsed  = req_data.time_ms - last_update_ff;
      if (descending_ff) begin
         stepped = {2'b00, sweep_freq_ff} - {6'b0, sweep_step_ff};
      end else begin
         stepped = {2'b00, sweep_freq_ff} + {6'b0, sweep_step_ff};
      end
      hit_hi   = $signed(stepped) >= $signed({2'b00, sweep_high_ff});
      after_hi = hit_hi ? {2'b00, sweep_high_ff} : stepped;
      desc_hi  = hit_hi ? 1'b1 : descending_ff;
      hit_lo   = $signed(after_hi) <= $signed({2'b00, sweep_low_ff});
      after_lo = hit_lo ? {2'b00, sweep_low_ff} : after_hi;
   end

   always_comb begin
      active_mode_in = active_mode_ff;
      last_update_in = last_update_ff;
      sweep_freq_in  = sweep_freq_ff;
      descending_in  = descending_ff;
      push           = '0;
      if (accept) begin
         if (req_data.command == CMD_SET) begin
            if (req_mode != active_mode_ff) begin
               active_mode_in = req_mode;
               last_update_in = req_data.time_ms;
               push.valid     = 1'b1;
               unique case (req_mode)
                  MODE_ALARM: begin
                     sweep_freq_in = sweep_low_ff;
                     descending_in = 1'b0;
                     push.freq     = sweep_low_ff;
                  end
                  MODE_STEADY: push.freq = steady_ff;
                  default:     push.freq = '0;
               endcase
            end
         end else if (active_mode_ff == MODE_ALARM && elapsed >= {16'b0, interval_ff}) begin
            last_update_in = req_data.time_ms;
            sweep_freq_in  = after_lo[15:0];
            descending_in  = hit_lo ? 1'b0 : desc_hi;
            push.valid     = 1'b1;
            push.freq      = after_lo[15:0];
         end
      end
   end

endmodule

[hdl/ssg_queue.sv]
// ---------------------------------------------------------------------------
// ssg_queue
// Small FIFO of tone frequencies between the front and the back.
// ---------------------------------------------------------------------------
module ssg_queue
   import ssg_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  tone_entry_type push,
   input  logic           pop,
   output logic           full,
   output tone_entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W_Q = $clog2(DEPTH + 1);

   logic [15:0]        mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0] count_ff,  count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W_Q'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.freq  = mem[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.freq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

endmodule

[hdl/ssg_back.sv]
// ---------------------------------------------------------------------------
// ssg_back
// Turns a tone frequency into PWM settings with a bit-serial divider and
// holds the result in the output register.
// ---------------------------------------------------------------------------
module ssg_back
   import ssg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  tone_entry_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data
);

   back_state_type state_ff, state_in;

   logic [15:0]         freq_ff,  freq_in;
   logic [DIV_BITS-1:0] quot_ff,  quot_in;
   logic [15:0]         rem_ff,   rem_in;
   logic [CNT_W-1:0]    cnt_ff,   cnt_in;
   logic                zero_ff,  zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff,  rsp_data_in;

   logic [16:0]         trial;
   logic [16:0]         diff;
   logic                fits;
   logic [DIV_BITS-1:0] quot_m1;
   logic [15:0]         reload;
   logic                out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff     <= freq_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   // restoring division, one quotient bit a cycle; dividend shifts out of quot
   always_comb begin
      trial   = {rem_ff, quot_ff[DIV_BITS-1]};
      fits    = trial >= {1'b0, freq_ff};
      diff    = trial - {1'b0, freq_ff};
      quot_m1 = quot_ff - 1'b1;
      reload  = (quot_m1[DIV_BITS-1:16] != '0) ? 16'hFFFF : quot_m1[15:0];
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      freq_in      = freq_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      zero_in      = zero_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               freq_in  = head.freq;
               quot_in  = TIMER_CLOCK;
               rem_in   = '0;
               cnt_in   = '0;
               zero_in  = (head.freq == '0);
               state_in = (head.freq == '0) ? BACK_HOLD : BACK_DIV;
            end
         end
         BACK_DIV: begin
            quot_in = {quot_ff[DIV_BITS-2:0], fits};
            rem_in  = fits ? diff[15:0] : trial[15:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_BITS - 1)) begin
               state_in = BACK_HOLD;
            end
         end
         BACK_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (zero_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in.pwm_enable    = 1'b1;
                  rsp_data_in.reload_value  = reload;
                  rsp_data_in.compare_value = reload[15:1];
                  rsp_data_in.tone_hz       = freq_ff;
               end
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Siren sweep tone generator testbench
// Drives off/steady/alarm mode requests and millisecond ticks through the
// request channel, predicts the PWM settings of every accepted transaction
// and checks each result transaction field by field, in order. Runs directed
// corner cases, then random sweep bursts under several CSR settings and
// idle/stall patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
import ssg_pkg::*;

class tone_scoreboard;
   localparam int unsigned RELOAD_MAX = 65535;

   bit [15:0] low_hz, high_hz, steady_hz, interval_ms;
   bit [11:0] step_hz;
   bit [1:0]  mode;
   bit [31:0] last_ms;
   bit [15:0] freq_hz;
   bit        descending;
   rsp_type   tone_q[$];
   int        errors;

   function new();
      low_hz      = RST_SWEEP_LOW;
      high_hz     = RST_SWEEP_HIGH;
      step_hz     = RST_SWEEP_STEP;
      interval_ms = RST_INTERVAL;
      steady_hz   = RST_STEADY;
      mode        = MODE_OFF;
      last_ms     = '0;
      freq_hz     = 16'd1000;
      descending  = 1'b0;
      errors      = 0;
   endfunction

   function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_SWEEP_LOW:  low_hz = val;
         CSR_SWEEP_HIGH: high_hz = val;
         CSR_SWEEP_STEP: step_hz = val[11:0];
         CSR_INTERVAL:   interval_ms = val;
         CSR_STEADY:     steady_hz = val;
         default: ;
      endcase
   endfunction

   // zero frequency means PWM stopped: all fields zero
   function rsp_type pwm_settings(bit [15:0] f);
      rsp_type     t;
      int unsigned reload;
      t = '0;
      if (f == 0) return t;
      reload = TIMER_CLOCK / f - 1;
      if (reload > RELOAD_MAX) reload = RELOAD_MAX;
      t.pwm_enable    = 1'b1;
      t.reload_value  = reload[15:0];
      t.compare_value = reload[15:1];
      t.tone_hz       = f;
      return t;
   endfunction

   function void note_request(req_type r);
      bit [1:0]  m;
      bit [31:0] elapsed;
      int        f, lo, hi, st;
      if (r.command == CMD_SET) begin
         m = (r.mode == MODE_RSVD) ? MODE_OFF : r.mode;
         if (m == mode) return;
         mode    = m;
         last_ms = r.time_ms;
         if (m == MODE_ALARM) begin
            freq_hz    = low_hz;
            descending = 1'b0;
            tone_q.push_back(pwm_settings(freq_hz));
         end else if (m == MODE_STEADY) begin
            tone_q.push_back(pwm_settings(steady_hz));
         end else begin
            tone_q.push_back(pwm_settings(16'd0));
         end
         return;
      end
      if (mode != MODE_ALARM) return;
      elapsed = r.time_ms - last_ms;
      if (elapsed < interval_ms) return;
      last_ms = r.time_ms;
      // signed math so a descent below zero clamps instead of wrapping
      f  = freq_hz;
      lo = low_hz;
      hi = high_hz;
      st = step_hz;
      f  = descending ? f - st : f + st;
      // high clamp first, low clamp wins when bounds are reversed
      if (f >= hi) begin
         f = hi;
         descending = 1'b1;
      end
      if (f <= lo) begin
         f = lo;
         descending = 1'b0;
      end
      freq_hz = f[15:0];
      tone_q.push_back(pwm_settings(freq_hz));
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (tone_q.size() == 0) begin
         $error("unexpected transaction: tone_hz %0d", got.tone_hz);
         errors++;
         return;
      end
      want = tone_q.pop_front();
      compare_field("pwm_enable", want.pwm_enable, got.pwm_enable);
      compare_field("reload_value", want.reload_value, got.reload_value);
      compare_field("compare_value", want.compare_value, got.compare_value);
      compare_field("tone_hz", want.tone_hz, got.tone_hz);
   endfunction

   function int pending();
      return tone_q.size();
   endfunction
endclass

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 175;
   localparam int NUM_PHASES   = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tone_scoreboard sb = new();

   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        hold_requests = 0;
   int        hold_seen = 0;
   int        hold_left = 0;
   bit [15:0] cfg_interval = RST_INTERVAL;
   bit [31:0] now_ms = '0;

   siren_sweep_tone_generator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: check accepted transactions, pick next stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
         end
      end
   end

   // valid stays high across back-to-back transactions
   task automatic send_req(input logic cmd, input logic [1:0] md, input logic [31:0] t);
      req_type r;
      r.command = cmd;
      r.mode    = md;
      r.time_ms = t;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_tone_settings(input int lo, input int hi, input int st,
                                     input int iv, input int sd);
      logic [CSR_IDX_W-1:0]  idx[5];
      logic [CSR_DATA_W-1:0] vals[5];
      idx  = '{CSR_SWEEP_LOW, CSR_SWEEP_HIGH, CSR_SWEEP_STEP, CSR_INTERVAL, CSR_STEADY};
      vals = '{lo[15:0], hi[15:0], {4'd0, st[11:0]}, iv[15:0], sd[15:0]};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_reg(idx[i], vals[i]);
      end
      csr_we <= 1'b0;
      cfg_interval = iv[15:0];
   endtask

   task automatic send_tick();
      bit [31:0] delta;
      case ($urandom_range(9))
         0: delta = (cfg_interval != 0) ? $urandom_range(cfg_interval - 1) : 0;
         8: delta = cfg_interval + $urandom;
         9: delta = $urandom;
         default: delta = cfg_interval + $urandom_range(2);
      endcase
      now_ms = now_ms + delta;
      send_req(CMD_TICK, 2'($urandom_range(3)), now_ms);
   endtask

   // mostly alarm bursts with well-paced ticks, the rest stray requests
   task automatic run_random(input int n_items);
      int sent;
      int kind;
      int burst;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            now_ms = $urandom;
            if ($urandom_range(1)) begin
               send_req(CMD_SET, MODE_OFF, now_ms);
               sent++;
            end
            send_req(CMD_SET, MODE_ALARM, now_ms);
            sent++;
            burst = $urandom_range(16, 4);
            repeat (burst) begin
               send_tick();
               sent++;
            end
         end else if (kind < 85) begin
            now_ms = $urandom;
            send_req(CMD_SET, 2'($urandom_range(3)), now_ms);
            sent++;
         end else begin
            send_req(CMD_TICK, 2'($urandom_range(3)), $urandom);
            sent++;
         end
      end
   endtask

   initial begin
      int lo, hi, st, iv, sd;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: mode changes, repeats, interval edge, time wrap
      send_req(CMD_TICK, MODE_OFF, 32'd0);
      send_req(CMD_TICK, MODE_RSVD, 32'hFFFF_FFFF);
      send_req(CMD_SET, MODE_OFF, 32'd5);
      send_req(CMD_SET, MODE_STEADY, 32'd100);
      send_req(CMD_SET, MODE_STEADY, 32'd110);
      send_req(CMD_TICK, MODE_ALARM, 32'd200);
      send_req(CMD_SET, MODE_ALARM, 32'd1000);
      send_req(CMD_TICK, MODE_OFF, 32'd1019);
      send_req(CMD_TICK, MODE_OFF, 32'd1020);
      send_req(CMD_SET, MODE_RSVD, 32'd1030);
      send_req(CMD_SET, MODE_ALARM, 32'hFFFF_FFF0);
      send_req(CMD_TICK, MODE_OFF, 32'd4);
      wait_drained();

      // zero low bound and steady tone, zero interval, descent below zero
      load_tone_settings(0, 100, 4095, 0, 0);
      send_req(CMD_SET, MODE_STEADY, 32'd7);
      send_req(CMD_SET, MODE_ALARM, 32'd8);
      send_req(CMD_TICK, MODE_OFF, 32'd8);
      send_req(CMD_TICK, MODE_OFF, 32'd8);
      send_req(CMD_TICK, MODE_OFF, 32'd9);
      send_req(CMD_SET, MODE_OFF, 32'd9);
      wait_drained();

      // reversed bounds, saturated reload, max tone, max interval
      load_tone_settings(15, 10, 1, 65535, 65535);
      send_req(CMD_SET, MODE_STEADY, 32'd0);
      send_req(CMD_SET, MODE_ALARM, 32'd5);
      send_req(CMD_TICK, MODE_OFF, 32'd65539);
      send_req(CMD_TICK, MODE_OFF, 32'd65540);
      send_req(CMD_SET, MODE_OFF, 32'd0);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p % 4)
            0: begin
               lo = $urandom_range(2000, 16);
               hi = lo + $urandom_range(3000);
               st = $urandom_range(400, 1);
               iv = $urandom_range(50);
               sd = $urandom_range(65535);
            end
            1: begin
               lo = 1;
               hi = 65535;
               st = 4095;
               iv = $urandom_range(3);
               sd = 65535;
            end
            2: begin
               lo = $urandom_range(200);
               hi = $urandom_range(lo);
               st = $urandom_range(4095);
               iv = $urandom_range(5);
               sd = 0;
            end
            default: begin
               lo = $urandom_range(65535);
               hi = $urandom_range(65535);
               st = $urandom_range(4095);
               iv = $urandom_range(65535);
               sd = $urandom_range(65535);
            end
         endcase
         load_tone_settings(lo, hi, st, iv, sd);
         case ((p + p / 4) % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         // long receiver hold-off while the sender keeps pushing
         if (p == 4) hold_requests++;
         run_random(PHASE_ITEMS);
         wait_drained();
      end

      if (sb.errors == 0 && sb.pending() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/ssg_pkg.sv
hdl/ssg_front.sv
hdl/ssg_queue.sv
hdl/ssg_back.sv
hdl/siren_sweep_tone_generator.sv
sim/tb_top.sv
